// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the frame time table RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
	else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ----- rtl/sftt_pkg.sv -----
// ----------------------------------------------------------------------------
// sftt_pkg
// Types and constants shared by the sorted frame time table.
// ----------------------------------------------------------------------------
package sftt_pkg;
	localparam int unsigned TableDepth = 64;
	localparam int unsigned IdxW = $clog2(TableDepth);
	localparam int unsigned CntW = $clog2(TableDepth + 1);

	localparam logic [2:0] CMD_INSERT = 3'd0;
	localparam logic [2:0] CMD_REMOVE = 3'd1;
	localparam logic [2:0] CMD_LOOKUP = 3'd2;
	localparam logic [2:0] CMD_EVICT  = 3'd3;
	localparam logic [2:0] CMD_CLEAR  = 3'd4;
	localparam logic [2:0] CMD_SPANS  = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam logic [1:0] REG_BEHIND = 2'd0;
	localparam logic [1:0] REG_AHEAD  = 2'd1;
	localparam logic [1:0] REG_TOL    = 2'd2;

	localparam logic [29:0] BytesMax = '1;

	typedef struct packed {
		logic [32:0] tm;
		logic [23:0] len;
		logic        key;
		logic [23:0] size;
	} frame_t;

	// drop rule applied by the bench table model while compacting
	typedef enum logic [1:0] {
		DROP_RANGE = 2'd0,
		DROP_BELOW = 2'd1,
		DROP_ABOVE = 2'd2,
		DROP_NONE  = 2'd3
	} drop_mode_t;

	// per-cycle chain control from the sequencer
	typedef struct packed {
		logic        shift_in;  // insert: cells after pos take left neighbor
		logic        load;      // insert: write new frame at pos
		logic [IdxW-1:0] pos;
		logic        rotate;    // walk: entry 0 to the tail, rest shift left
	} chain_ctl_t;
endpackage

// ----- rtl/sorted_frame_time_table.sv -----
// ----------------------------------------------------------------------------
// Sorted frame time table: 64 cells form a ring that rotates one place a cycle.
// Insert walks the held frames to find its slot and then loads it (done with
// ST_FULL and no walk when full); remove, lookup and spans walk the frames
// once; evict walks once more over the kept frames when the first pass freed
// too few bytes; clear and unknown commands need no walk. Items wait while busy.
// Reset clears fill count and control and loads configuration defaults; cell contents stay undefined.
// ----------------------------------------------------------------------------
module sorted_frame_time_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic [2:0]  command,
	input  logic [32:0] frame_time,
	input  logic [23:0] frame_length,
	input  logic        frame_is_key,
	input  logic [23:0] frame_size,
	input  logic [32:0] time_start,
	input  logic [32:0] time_end,
	input  logic [29:0] bytes_wanted,
	output logic        done,
	output logic [1:0]  status,
	output logic [32:0] found_time,
	output logic [23:0] found_length,
	output logic        found_is_key,
	output logic [23:0] found_size,
	output logic [32:0] span_begin,
	output logic [33:0] span_finish,
	output logic [29:0] bytes_freed,
	output logic        last_item
);
	import sftt_pkg::*;
	`include "assert_macros.svh"

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SCAN  = 6'b000010,
		S_PASS1 = 6'b000100,
		S_PASS2 = 6'b001000,
		S_ALIGN = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t state_q;
	logic [31:0] behind_q, ahead_q;
	logic [23:0] tol_q;
	logic [CntW-1:0] fill_q, cnt_q, keep_q, rot_q;
	logic [2:0]  cmd_q;
	frame_t      new_q;
	logic [32:0] ts_q, te_q;
	logic [33:0] lim_q;
	logic [29:0] want_q, freed_q;
	logic [IdxW-1:0] pos_q;
	logic        pos_found_q, lk_hit_q, sp_open_q, sp_stop_q;
	frame_t      lk_q;
	logic [32:0] sb_q;
	logic [33:0] se_q;
	logic [6:0]  nsp_q;

	chain_ctl_t ctl;
	frame_t cells [TableDepth];
	frame_t head;
	logic [IdxW-1:0] tail_idx;

	assign head = cells[0];

	// chain of cells; tail is the last valid slot for rotation
	for (genvar g = 0; g < TableDepth; g++) begin : g_cell
		sftt_cell u_cell (
			.clk        (clk),
			.my_idx     (IdxW'(g)),
			.ctl        (ctl),
			.new_frame  (new_q),
			.left_frame (cells[(g == 0) ? 0 : g - 1]),
			.right_frame(cells[(g == TableDepth - 1) ? g : g + 1]),
			.tail_frame (head),
			.is_tail    (IdxW'(g) == tail_idx),
			.frame      (cells[g])
		);
	end

	logic walking, drop_now, rot_done;
	logic [29:0] add_sat;
	logic [30:0] add_sum;
	logic [33:0] end_now;
	logic [34:0] merge_lim;

	assign walking  = (state_q == S_PASS1) || (state_q == S_PASS2) || (state_q == S_SCAN);
	assign rot_done = (cnt_q == rot_q);
	assign end_now  = {1'b0, head.tm} + {10'd0, head.len};
	assign merge_lim = {1'b0, se_q} + {11'd0, tol_q};
	assign add_sum  = {1'b0, freed_q} + {7'd0, head.size};
	assign add_sat  = add_sum[30] ? BytesMax : add_sum[29:0];

	// drop decision for the head entry during compaction passes
	always_comb begin
		drop_now = 1'b0;
		if (state_q == S_PASS1 || state_q == S_PASS2) begin
			case (cmd_q)
				CMD_REMOVE: drop_now = (head.tm >= ts_q) && (head.tm < te_q);
				CMD_EVICT:  drop_now = (state_q == S_PASS1) ?
					({1'b0, head.tm} < lim_q) : ({1'b0, head.tm} > lim_q);
				default:    drop_now = 1'b0;
			endcase
		end
	end

	// ring rotates over the kept entries; dropped ones fall out
	always_comb begin
		ctl = '0;
		ctl.pos = pos_q;
		tail_idx = IdxW'(keep_q + CntW'(fill_q - cnt_q) - CntW'(1));
		if (walking && !rot_done) begin
			ctl.rotate = 1'b1;
			if (drop_now) tail_idx = IdxW'(TableDepth - 1);
		end
		if (state_q == S_ALIGN) begin
			ctl.shift_in = 1'b1;
			ctl.load = 1'b1;
		end
	end

	assign busy = (state_q != S_IDLE);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			behind_q <= 32'd900000;
			ahead_q  <= 32'd2700000;
			tol_q    <= 24'd9000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BEHIND: behind_q <= cfg_data;
				REG_AHEAD:  ahead_q  <= cfg_data;
				REG_TOL:    tol_q    <= cfg_data[23:0];
				default:    ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			done    <= 1'b0;
			cnt_q   <= '0;
			keep_q  <= '0;
			rot_q   <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q  <= command;
						new_q  <= '{frame_time, frame_length, frame_is_key, frame_size};
						ts_q   <= time_start;
						te_q   <= time_end;
						want_q <= bytes_wanted;
						freed_q <= '0;
						cnt_q  <= '0;
						keep_q <= '0;
						rot_q  <= fill_q;
						pos_q  <= '0;
						pos_found_q <= 1'b0;
						lk_hit_q <= 1'b0;
						sp_open_q <= 1'b0;
						sp_stop_q <= 1'b0;
						nsp_q <= '0;
						lim_q <= (time_start > {1'b0, behind_q}) ?
							{1'b0, time_start - {1'b0, behind_q}} : 34'd0;
						status <= ST_OK;
						found_time <= '0; found_length <= '0;
						found_is_key <= 1'b0; found_size <= '0;
						span_begin <= '0; span_finish <= '0; bytes_freed <= '0;
						last_item <= 1'b1;
						case (command)
							CMD_INSERT: begin
								if (fill_q == CntW'(TableDepth)) begin
									status <= ST_FULL; done <= 1'b1;
								end else state_q <= S_SCAN;
							end
							CMD_REMOVE, CMD_EVICT: state_q <= S_PASS1;
							CMD_LOOKUP, CMD_SPANS: state_q <= S_SCAN;
							CMD_CLEAR: begin fill_q <= '0; done <= 1'b1; end
							default: done <= 1'b1;
						endcase
					end
				end
				S_SCAN: begin
					if (!rot_done) begin
						cnt_q  <= cnt_q + CntW'(1);
						keep_q <= keep_q + CntW'(1);
						case (cmd_q)
							CMD_INSERT: if (!pos_found_q && head.tm > new_q.tm) begin
								pos_found_q <= 1'b1; pos_q <= IdxW'(cnt_q);
							end
							CMD_LOOKUP: if (head.tm <= ts_q) begin
								lk_hit_q <= 1'b1; lk_q <= head;
							end
							default: begin
								if (!sp_open_q) begin
									sp_open_q <= 1'b1; sb_q <= head.tm; se_q <= end_now;
								end else if (!sp_stop_q) begin
									if ({2'b0, head.tm} > merge_lim) begin
										done <= 1'b1; last_item <= 1'b0;
										span_begin <= sb_q; span_finish <= se_q;
										nsp_q <= nsp_q + 7'd1;
										if (nsp_q == 7'd63) begin
											sp_stop_q <= 1'b1; last_item <= 1'b1;
										end
										sb_q <= head.tm;
									end
									se_q <= end_now;
								end
							end
						endcase
					end else begin
						case (cmd_q)
							CMD_INSERT: begin
								if (!pos_found_q) pos_q <= IdxW'(fill_q);
								state_q <= S_ALIGN;
							end
							CMD_LOOKUP: begin
								done <= 1'b1; state_q <= S_IDLE;
								if (lk_hit_q) begin
									found_time <= lk_q.tm; found_length <= lk_q.len;
									found_is_key <= lk_q.key; found_size <= lk_q.size;
								end else status <= ST_EMPTY;
							end
							default: begin
								state_q <= S_IDLE;
								if (!sp_stop_q) begin
									done <= 1'b1; last_item <= 1'b1;
									if (sp_open_q) begin
										span_begin <= sb_q; span_finish <= se_q;
									end else status <= ST_EMPTY;
								end
							end
						endcase
					end
				end
				S_PASS1, S_PASS2: begin
					if (!rot_done) begin
						cnt_q <= cnt_q + CntW'(1);
						if (drop_now) freed_q <= add_sat;
						else keep_q <= keep_q + CntW'(1);
					end else begin
						fill_q <= keep_q;
						cnt_q <= '0; keep_q <= '0; rot_q <= keep_q;
						lim_q <= {1'b0, ts_q} + {2'b0, ahead_q};
						if (state_q == S_PASS1 && cmd_q == CMD_EVICT && freed_q < want_q)
							state_q <= S_PASS2;
						else begin
							bytes_freed <= (cmd_q == CMD_EVICT) ? freed_q : '0;
							done <= 1'b1; state_q <= S_IDLE;
						end
					end
				end
				S_ALIGN: begin
					fill_q <= fill_q + CntW'(1);
					done <= 1'b1; state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ASSERT_NEVER(a_fill_range, clk, arst_n, fill_q > CntW'(TableDepth))
	`ASSERT_CLK(a_busy_no_done_idle, clk, arst_n, (state_q == S_ALIGN) |=> done)
	`ASSERT_NEVER(a_keep_le_cnt, clk, arst_n, keep_q > cnt_q)
endmodule

// ----- rtl/sftt_cell.sv -----
// ----------------------------------------------------------------------------
// sftt_cell
// One table slot: holds a frame and hands it to a neighbor on command.
// ----------------------------------------------------------------------------
module sftt_cell (
	input  logic                 clk,
	input  logic [sftt_pkg::IdxW-1:0] my_idx,
	input  sftt_pkg::chain_ctl_t ctl,
	input  sftt_pkg::frame_t     new_frame,
	input  sftt_pkg::frame_t     left_frame,
	input  sftt_pkg::frame_t     right_frame,
	input  sftt_pkg::frame_t     tail_frame,
	input  logic                 is_tail,
	output sftt_pkg::frame_t     frame
);
	import sftt_pkg::*;

	frame_t frame_q;
	assign frame = frame_q;

	// load, shift right for insert, or rotate left for a walk
	always_ff @(posedge clk) begin
		if (ctl.load && my_idx == ctl.pos) begin
			frame_q <= new_frame;
		end else if (ctl.shift_in && my_idx > ctl.pos) begin
			frame_q <= left_frame;
		end else if (ctl.rotate) begin
			frame_q <= is_tail ? tail_frame : right_frame;
		end
	end
endmodule

// ----- sim/tb_sorted_frame_time_table.sv -----
// ----------------------------------------------------------------------------
// tb_sorted_frame_time_table
// Self-checking bench for the sorted frame time table. A directed table of
// commands is followed by random command streams. Every item goes through an
// internal table model that predicts each result, and the DUT's results are
// checked field by field in order against that prediction.
// ----------------------------------------------------------------------------
module tb_sorted_frame_time_table;
	timeunit 1ns;
	timeprecision 1ps;
	import sftt_pkg::*;

	localparam int Depth = TableDepth;
	localparam int IdleLimit = 20000;
	localparam logic [29:0] Bytes30 = 30'h3FFFFFFF;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [32:0] ftime;
		logic [23:0] flen;
		logic        fkey;
		logic [23:0] fsize;
		logic [32:0] tstart;
		logic [32:0] tend;
		logic [29:0] wanted;
	} item_t;

	typedef struct packed {
		logic [1:0]  st;
		logic [32:0] ftm;
		logic [23:0] flen;
		logic        fkey;
		logic [23:0] fsize;
		logic [32:0] sbeg;
		logic [33:0] sfin;
		logic [29:0] freed;
		logic        last;
	} res_t;

	// one row of the directed table; chk marks a typed-in expected result
	typedef struct packed {
		item_t it;
		logic  chk;
		res_t  want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic [2:0] command = '0;
	logic [32:0] frame_time = '0;
	logic [23:0] frame_length = '0;
	logic frame_is_key = 1'b0;
	logic [23:0] frame_size = '0;
	logic [32:0] time_start = '0;
	logic [32:0] time_end = '0;
	logic [29:0] bytes_wanted = '0;
	logic done;
	logic [1:0] status;
	logic [32:0] found_time;
	logic [23:0] found_length;
	logic found_is_key;
	logic [23:0] found_size;
	logic [32:0] span_begin;
	logic [33:0] span_finish;
	logic [29:0] bytes_freed;
	logic last_item;

	sorted_frame_time_table u_dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// table model
	logic [31:0] m_behind, m_ahead;
	logic [23:0] m_tol;
	frame_t m_tab [Depth];
	int m_fill;

	res_t pending_results [$];
	row_t rows [$];
	int errors = 0;
	int idle_cycles = 0;
	int results_seen = 0;
	int items_sent = 0;
	int span_results = 0;

	function automatic res_t blank_res();
		res_t r;
		r = '0;
		r.last = 1'b1;
		return r;
	endfunction

	// mode: DROP_RANGE lo<=t<hi, DROP_BELOW t<lo, DROP_ABOVE t>lo
	function automatic logic [29:0] compact_table(drop_mode_t mode, logic [34:0] lo,
			logic [34:0] hi);
		logic [30:0] freed;
		int w;
		logic dropit;
		freed = '0;
		w = 0;
		for (int r = 0; r < m_fill; r++) begin
			case (mode)
				DROP_RANGE: dropit = ({2'b0, m_tab[r].tm} >= lo) && ({2'b0, m_tab[r].tm} < hi);
				DROP_BELOW: dropit = {2'b0, m_tab[r].tm} < lo;
				default:    dropit = {2'b0, m_tab[r].tm} > lo;
			endcase
			if (dropit) begin
				freed = freed + m_tab[r].size;
				if (freed > {1'b0, Bytes30}) freed = {1'b0, Bytes30};
			end else begin
				m_tab[w] = m_tab[r];
				w++;
			end
		end
		m_fill = w;
		return freed[29:0];
	endfunction

	task automatic predict_table(item_t it);
		res_t r;
		int pos;
		int n;
		logic [34:0] sbeg, send;
		logic [30:0] freed;
		r = blank_res();
		case (it.cmd)
			CMD_INSERT: begin
				if (m_fill >= Depth) begin
					r.st = ST_FULL;
				end else begin
					pos = m_fill;
					for (int i = 0; i < m_fill; i++)
						if (m_tab[i].tm > it.ftime) begin
							pos = i;
							break;
						end
					for (int i = m_fill; i > pos; i--) m_tab[i] = m_tab[i-1];
					m_tab[pos] = '{tm: it.ftime, len: it.flen, key: it.fkey, size: it.fsize};
					m_fill++;
				end
				pending_results.push_back(r);
			end
			CMD_REMOVE: begin
				void'(compact_table(DROP_RANGE, {2'b0, it.tstart}, {2'b0, it.tend}));
				pending_results.push_back(r);
			end
			CMD_LOOKUP: begin
				r.st = ST_EMPTY;
				for (int i = m_fill - 1; i >= 0; i--)
					if (m_tab[i].tm <= it.tstart) begin
						r.st = ST_OK;
						r.ftm = m_tab[i].tm;
						r.flen = m_tab[i].len;
						r.fkey = m_tab[i].key;
						r.fsize = m_tab[i].size;
						break;
					end
				pending_results.push_back(r);
			end
			CMD_EVICT: begin
				freed = '0;
				if ({2'b0, it.tstart} > {3'b0, m_behind})
					freed = compact_table(DROP_BELOW, {2'b0, it.tstart} - m_behind, '0);
				if (freed < it.wanted) begin
					freed = freed + compact_table(DROP_ABOVE, {2'b0, it.tstart} + m_ahead, '0);
					if (freed > {1'b0, Bytes30}) freed = {1'b0, Bytes30};
				end
				r.freed = freed[29:0];
				pending_results.push_back(r);
			end
			CMD_CLEAR: begin
				m_fill = 0;
				pending_results.push_back(r);
			end
			CMD_SPANS: begin
				if (m_fill == 0) begin
					r.st = ST_EMPTY;
					pending_results.push_back(r);
				end else begin
					n = 0;
					sbeg = m_tab[0].tm;
					send = m_tab[0].tm + m_tab[0].len;
					for (int i = 1; i < m_fill; i++) begin
						if ({2'b0, m_tab[i].tm} > send + m_tol) begin
							r = '0;
							r.sbeg = sbeg[32:0];
							r.sfin = send[33:0];
							n++;
							r.last = (n == 64);
							pending_results.push_back(r);
							if (n == 64) return;
							sbeg = m_tab[i].tm;
						end
						send = m_tab[i].tm + m_tab[i].len;
					end
					r = '0;
					r.sbeg = sbeg[32:0];
					r.sfin = send[33:0];
					r.last = 1'b1;
					pending_results.push_back(r);
				end
			end
			default: pending_results.push_back(r);
		endcase
	endtask

	// check results against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			res_t e;
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("unexpected result status=%0d", status);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (e.sfin != 0 || e.sbeg != 0) span_results++;
				if (status !== e.st) begin
					$error("status exp %0d got %0d", e.st, status); errors++;
				end
				if (found_time !== e.ftm) begin
					$error("found_time exp %0h got %0h", e.ftm, found_time); errors++;
				end
				if (found_length !== e.flen) begin
					$error("found_length exp %0h got %0h", e.flen, found_length); errors++;
				end
				if (found_is_key !== e.fkey) begin
					$error("found_is_key exp %0b got %0b", e.fkey, found_is_key); errors++;
				end
				if (found_size !== e.fsize) begin
					$error("found_size exp %0h got %0h", e.fsize, found_size); errors++;
				end
				if (span_begin !== e.sbeg) begin
					$error("span_begin exp %0h got %0h", e.sbeg, span_begin); errors++;
				end
				if (span_finish !== e.sfin) begin
					$error("span_finish exp %0h got %0h", e.sfin, span_finish); errors++;
				end
				if (bytes_freed !== e.freed) begin
					$error("bytes_freed exp %0h got %0h", e.freed, bytes_freed); errors++;
				end
				if (last_item !== e.last) begin
					$error("last_item exp %0b got %0b", e.last, last_item); errors++;
				end
			end
		end
	end

	// watchdog on cycles with no accepted item or result
	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("sorted_frame_time_table regression: fail");
			$finish;
		end
	end

	int send_idle_pct = 0;

	// drive one item and hold it until the accepting edge; start stays high
	task automatic send_item(item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		command <= it.cmd;
		frame_time <= it.ftime;
		frame_length <= it.flen;
		frame_is_key <= it.fkey;
		frame_size <= it.fsize;
		time_start <= it.tstart;
		time_end <= it.tend;
		bytes_wanted <= it.wanted;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_table(it);
		items_sent++;
	endtask

	// send an item whose expected result is typed in
	task automatic send_fixed(item_t it, res_t want);
		res_t got;
		send_item(it);
		got = pending_results[pending_results.size() - 1];
		if (got !== want) begin
			$error("directed row cmd %0d: typed result disagrees with table model", it.cmd);
			errors++;
		end
	endtask

	// drop start and hold until every expected result has come
	task automatic wait_results();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic drain();
		wait_results();
		repeat (2 * Depth + 8) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_BEHIND: m_behind = val;
			REG_AHEAD:  m_ahead = val;
			default:    m_tol = val[23:0];
		endcase
	endtask

	function automatic item_t mk(logic [2:0] c, logic [32:0] ft, logic [23:0] fl,
			logic fk, logic [23:0] fs, logic [32:0] ts, logic [32:0] te, logic [29:0] bw);
		item_t it;
		it = '{cmd: c, ftime: ft, flen: fl, fkey: fk, fsize: fs, tstart: ts, tend: te,
			wanted: bw};
		return it;
	endfunction

	function automatic void add_row(item_t it, logic chk, res_t want);
		row_t w;
		w.it = it;
		w.chk = chk;
		w.want = want;
		rows.push_back(w);
	endfunction

	// random item; times cluster near base so spans and ranges bite
	function automatic item_t rand_item(logic [32:0] base);
		item_t it;
		logic [32:0] t1, t2;
		int sel;
		sel = $urandom_range(99);
		t1 = base + 33'($urandom_range(400000));
		t2 = t1 + 33'($urandom_range(200000));
		if ($urandom_range(9) == 0) begin
			t1 = {1'($urandom_range(1)), $urandom()};
			t2 = {1'($urandom_range(1)), $urandom()};
		end
		it = mk(CMD_INSERT, t1, 24'($urandom_range(12000)), 1'($urandom_range(1)),
			24'($urandom()), t1, t2, 30'($urandom()));
		if ($urandom_range(7) == 0) begin
			it.flen = 24'($urandom());
			it.fsize = 24'($urandom());
		end
		if (sel < 50) it.cmd = CMD_INSERT;
		else if (sel < 60) it.cmd = CMD_REMOVE;
		else if (sel < 75) it.cmd = CMD_LOOKUP;
		else if (sel < 83) it.cmd = CMD_EVICT;
		else if (sel < 85) it.cmd = CMD_CLEAR;
		else if (sel < 96) it.cmd = CMD_SPANS;
		else it.cmd = 3'(6 + $urandom_range(1));
		if (it.cmd == CMD_EVICT)
			it.wanted = ($urandom_range(3) == 0) ? '0 : 30'($urandom_range(20000000));
		return it;
	endfunction

	initial begin
		item_t it;
		res_t r;
		logic [32:0] base;
		m_behind = 32'd900000;
		m_ahead = 32'd2700000;
		m_tol = 24'd9000;
		m_fill = 0;

		// directed table
		r = blank_res(); r.st = ST_EMPTY;
		add_row(mk(CMD_LOOKUP, '0, '0, 1'b0, '0, '1, '0, '0), 1'b1, r);
		add_row(mk(CMD_SPANS, '0, '0, 1'b0, '0, '0, '0, '0), 1'b1, r);
		r = blank_res();
		add_row(mk(CMD_INSERT, '1, '1, 1'b1, '1, '0, '0, '0), 1'b1, r);
		add_row(mk(CMD_INSERT, '0, '0, 1'b0, '0, '0, '0, '0), 1'b1, r);
		add_row(mk(CMD_INSERT, 33'd1000, 24'd500, 1'b1, 24'd77, '0, '0, '0), 1'b1, r);
		add_row(mk(CMD_INSERT, 33'd1000, 24'd600, 1'b0, 24'd88, '0, '0, '0), 1'b1, r);
		r.ftm = 33'd1000; r.flen = 24'd600; r.fsize = 24'd88;
		add_row(mk(CMD_LOOKUP, '0, '0, 1'b0, '0, 33'd1500, '0, '0), 1'b1, r);
		r = blank_res(); r.ftm = '1; r.flen = '1; r.fkey = 1'b1; r.fsize = '1;
		add_row(mk(CMD_LOOKUP, '0, '0, 1'b0, '0, '1, '0, '0), 1'b1, r);
		add_row(mk(CMD_SPANS, '0, '0, 1'b0, '0, '0, '0, '0), 1'b0, blank_res());
		add_row(mk(3'd7, '1, '1, 1'b1, '1, '1, '1, '1), 1'b0, blank_res());
		add_row(mk(CMD_REMOVE, '0, '0, 1'b0, '0, 33'd2000, 33'd1000, '0), 1'b0, blank_res());
		add_row(mk(CMD_REMOVE, '0, '0, 1'b0, '0, 33'd1000, 33'd1001, '0), 1'b0, blank_res());
		add_row(mk(CMD_EVICT, '0, '0, 1'b0, '0, 33'd5, '0, '1), 1'b0, blank_res());
		add_row(mk(CMD_EVICT, '0, '0, 1'b0, '0, '1, '0, '1), 1'b0, blank_res());
		add_row(mk(CMD_CLEAR, '0, '0, 1'b0, '0, '0, '0, '0), 1'b1, blank_res());
		// fill to full, then one more insert is dropped
		for (int i = 0; i < Depth; i++)
			add_row(mk(CMD_INSERT, 33'(i * 20000), 24'd100, i[0], 24'hFFFFFF, '0, '0, '0),
				1'b0, blank_res());
		r = blank_res(); r.st = ST_FULL;
		add_row(mk(CMD_INSERT, 33'd5, 24'd5, 1'b1, 24'd5, '0, '0, '0), 1'b1, r);
		add_row(mk(CMD_SPANS, '0, '0, 1'b0, '0, '0, '0, '0), 1'b0, blank_res());
		add_row(mk(CMD_EVICT, '0, '0, 1'b0, '0, 33'd1000000, '0, '1), 1'b0, blank_res());

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table row by row
		send_idle_pct = 27;
		foreach (rows[i]) begin
			if (rows[i].chk) send_fixed(rows[i].it, rows[i].want);
			else send_item(rows[i].it);
		end
		drain();

		// register extremes and random phases
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin write_reg(REG_BEHIND, '0); write_reg(REG_AHEAD, '0);
					write_reg(REG_TOL, '0); end
				1: begin write_reg(REG_BEHIND, '1); write_reg(REG_AHEAD, '1);
					write_reg(REG_TOL, 32'hFFFFFF); end
				2: begin write_reg(REG_BEHIND, 32'd200000); write_reg(REG_AHEAD, 32'd300000);
					write_reg(REG_TOL, 32'd3000); end
				default: begin write_reg(REG_BEHIND, $urandom()); write_reg(REG_AHEAD, $urandom());
					write_reg(REG_TOL, $urandom_range(20000)); end
			endcase
			cfg_we <= 1'b0;
			send_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 61 : 0;
			base = {1'($urandom_range(1)), $urandom()};
			for (int k = 0; k < 7; k++) begin
				it = rand_item(base);
				send_item(it);
				if (k == 3) wait_results();
			end
			drain();
		end

		$display("covered %0d items, %0d results (%0d span results), all commands and",
			items_sent, results_seen, span_results);
		$display("register extremes with full table, empty table and overflow rows");
		if (errors == 0 && pending_results.size() == 0) begin
			$display("sorted_frame_time_table regression: pass");
		end else begin
			$display("sorted_frame_time_table regression: fail");
		end
		$finish;
	end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/sftt_pkg.sv
rtl/sftt_cell.sv
rtl/sorted_frame_time_table.sv
sim/tb_sorted_frame_time_table.sv
